// File: rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants for the decimal text converter
// holds the place weights, the ascii offset and the beat structs that
// travel along the digit cell chain
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_W  = 16;
   localparam int CHAR_W   = 6;
   localparam int DIGIT_W  = 4;
   localparam int NUM_CELLS = 5;

   // ascii '0' in the 6-bit character field
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // decimal place of each cell, most significant first
   localparam int PLACE_WEIGHT [NUM_CELLS] = '{10000, 1000, 100, 10, 1};

   // work item handed from one cell to the next
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] rem;
      logic               started;
   } cell_beat_type;

   // character a cell offers to the result port
   typedef struct packed {
      logic              emit;
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } emit_beat_type;

endpackage

// File: rtl/b2da_cell.sv
// ----------------------------------------------------------------------------
// b2da_cell: one decimal place of the conversion chain
// registers the incoming remainder, extracts the digit of its place weight
// and hands the reduced remainder to the next cell
// ----------------------------------------------------------------------------
module b2da_cell #(
   parameter int WEIGHT = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  b2da_pkg::cell_beat_type beat_in,
   output b2da_pkg::cell_beat_type beat_out,
   output b2da_pkg::emit_beat_type emit_out
);

   localparam logic IS_LAST = (WEIGHT == 1);

   b2da_pkg::cell_beat_type  beat_ff;
   logic [b2da_pkg::DIGIT_W-1:0] digit;
   logic [b2da_pkg::VALUE_W:0]   sub;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.rem     <= beat_in.rem;
      beat_ff.started <= beat_in.started;
   end

   // parallel compares against the nine multiples of the weight
   always_comb begin
      digit = '0;
      sub   = '0;
      for (int m = 1; m < 10; m++) begin
         if ({1'b0, beat_ff.rem} >= (b2da_pkg::VALUE_W+1)'(m * WEIGHT)) begin
            digit = b2da_pkg::DIGIT_W'(m);
            sub   = (b2da_pkg::VALUE_W+1)'(m * WEIGHT);
         end
      end
   end

   always_comb begin
      beat_out.valid   = beat_ff.valid;
      beat_out.rem     = b2da_pkg::VALUE_W'({1'b0, beat_ff.rem} - sub);
      beat_out.started = beat_ff.started || (digit != '0);
   end

   always_comb begin
      emit_out.emit       = beat_ff.valid &&
                            ((digit != '0) || beat_ff.started || IS_LAST);
      emit_out.digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digit);
      emit_out.last       = IS_LAST;
   end

endmodule

// File: rtl/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: 16-bit binary word to decimal ascii text
// emits the digits of an unsigned word most significant first, leading
// zeros suppressed, one character per beat, last flag on the units digit
// ----------------------------------------------------------------------------
//
//   channel   ports                                  direction  handshake
//   request   start, busy, req_value[15:0]           in         start && !busy
//   response  rsp_valid, rsp_digit_char[5:0],        out        rsp_valid strobe
//             rsp_last
//
// - a request beat walks down a chain of five digit cells, one cell per
//   cycle; each cell offers its digit to the response register
// - a new request is taken only while busy is low; busy is raised after
//   each accept for a span set by the five-place cell chain
// - characters leave through the response register, most significant
//   first; one to five characters per request
// - synchronous active-high reset clears the chain, busy counter and strobe
// - the receiver cannot stall: each character is shown for one cycle only
//
module binary_to_decimal_ascii_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   output logic [5:0]  rsp_digit_char,
   output logic        rsp_last
);

   localparam int N = b2da_pkg::NUM_CELLS;

   // busy counter load value on an accept, one less than the number of cells
   localparam logic [2:0] HOLD_CYCLES = 3'(N - 1);

   b2da_pkg::cell_beat_type chain [N+1];
   b2da_pkg::emit_beat_type emits [N];
   logic [N-1:0]            emit_vec;

   logic [2:0]  busy_cnt_ff, busy_cnt_in;
   logic        accept;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_last_ff, rsp_last_in;

   assign accept = start && !busy;
   assign busy   = (busy_cnt_ff != '0);

   // request beat enters the head of the chain
   always_comb begin
      chain[0].valid   = accept;
      chain[0].rem     = req_value;
      chain[0].started = 1'b0;
   end

   for (genvar k = 0; k < N; k++) begin : g_cell
      b2da_cell #(
         .WEIGHT (b2da_pkg::PLACE_WEIGHT[k])
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (chain[k]),
         .beat_out (chain[k+1]),
         .emit_out (emits[k])
      );
      assign emit_vec[k] = emits[k].emit;
   end

   // accept throttle
   always_comb begin
      if (accept) begin
         busy_cnt_in = HOLD_CYCLES;
      end else if (busy_cnt_ff != '0) begin
         busy_cnt_in = busy_cnt_ff - 3'd1;
      end else begin
         busy_cnt_in = busy_cnt_ff;
      end
   end

   // only one request is ever in the chain, so at most one cell emits
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      for (int k = 0; k < N; k++) begin
         if (emits[k].emit) begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = emits[k].digit_char;
            rsp_last_in  = emits[k].last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_cnt_ff  <= busy_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   // checks

   a_single_emitter: assert property (@(posedge clock) disable iff (reset)
      $onehot0(emit_vec))
      else $error("more than one cell emitting in a cycle");

   a_units_digit_out: assert property (@(posedge clock) disable iff (reset)
      chain[N].valid |=> (rsp_valid && rsp_last))
      else $error("units digit beat missing or not flagged last");

   a_remainder_spent: assert property (@(posedge clock) disable iff (reset)
      chain[N].valid |-> (chain[N].rem == '0))
      else $error("remainder left after the units cell");

   a_accept_spacing: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request taken without holding off the next one");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_to_decimal_ascii_unit
// feeds 16-bit words through the start/busy command port and checks every
// ascii digit strobe against a local decimal converter; runs a directed set
// of edge values, then random words weighted by digit count, under phases
// with and without sender idle cycles
// ----------------------------------------------------------------------------
module tb;

   localparam int                CLK_HALF      = 2;
   localparam int                RESET_CYCLES  = 10;
   localparam int                STALL_LIMIT   = 1000;   // cycles with no beat at all
   localparam int                DRAIN_CYCLES  = 10;     // pause at the end that catches stray characters
   localparam int                WORDS_PER_PHASE = 82;
   localparam int                NUM_PHASES    = 4;
   localparam int                REPORT_MAX    = 10;
   localparam int                NUM_DIRECTED  = 24;
   localparam logic [b2da_pkg::CHAR_W-1:0] CHAR_ZERO = 6'd48;  // '0' in the 6-bit field

   // sender idle percentage of each phase
   localparam int unsigned PHASE_IDLE [NUM_PHASES] = '{0, 70, 0, 25};

   // place boundaries, zero, all ones, inner zeros
   localparam logic [b2da_pkg::VALUE_W-1:0] DIRECTED [NUM_DIRECTED] = '{
      16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
      16'd9999, 16'd10000, 16'd10001, 16'd65535, 16'd65534, 16'd65530,
      16'd10010, 16'd50005, 16'd60000, 16'd32768, 16'd43690, 16'd21845,
      16'd12345, 16'd90, 16'd808, 16'd7
   };

   // one expected character on the result port
   typedef struct packed {
      logic [b2da_pkg::CHAR_W-1:0] digit_char;
      logic                        last;
   } digit_beat_type;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         start     = 1'b0;
   logic                         busy;
   logic [b2da_pkg::VALUE_W-1:0] req_value = '0;
   logic                         rsp_valid;
   logic [b2da_pkg::CHAR_W-1:0]  rsp_digit_char;
   logic                         rsp_last;

   // words waiting to go out, characters waiting to come back
   logic [b2da_pkg::VALUE_W-1:0] words_to_send [$];
   digit_beat_type               pending_digits [$];

   int unsigned        sender_idle_pct = 0;
   int unsigned        fault_count     = 0;
   int unsigned        words_accepted  = 0;
   int unsigned        digits_checked  = 0;
   int unsigned        words_by_length [1:5] = '{0, 0, 0, 0, 0};
   int unsigned        quiet_cycles    = 0;

   binary_to_decimal_ascii_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // decimal text of one word: digits most significant first, leading zeros
   // dropped, units digit always sent and flagged as last
   function automatic void queue_decimal_digits(input logic [b2da_pkg::VALUE_W-1:0] word);
      int unsigned    remainder;
      int unsigned    weight;
      int unsigned    digit;
      int unsigned    length;
      bit             leading_seen;
      digit_beat_type beat;
      remainder    = word;
      weight       = 10000;
      length       = 0;
      leading_seen = 1'b0;
      for (int place = 0; place < 5; place++) begin
         digit     = remainder / weight;
         remainder = remainder - digit * weight;
         if (digit != 0 || leading_seen || weight == 1) begin
            leading_seen    = 1'b1;
            beat.digit_char = CHAR_ZERO + b2da_pkg::CHAR_W'(digit);
            beat.last       = (weight == 1);
            pending_digits.push_back(beat);
            length++;
         end
         weight = weight / 10;
      end
      words_by_length[length]++;
   endfunction

   function automatic void note_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_MAX)
         $display("tb: mismatch at %0t: %s", $realtime, what);
   endfunction

   // random word, mostly spread evenly over the five digit counts so short
   // numbers show up as often as long ones
   function automatic logic [b2da_pkg::VALUE_W-1:0] pick_word();
      int unsigned n_digits;
      if ($urandom_range(99) < 25)
         return b2da_pkg::VALUE_W'($urandom_range(65535, 0));
      n_digits = $urandom_range(5, 1);
      case (n_digits)
         1: return b2da_pkg::VALUE_W'($urandom_range(9, 0));
         2: return b2da_pkg::VALUE_W'($urandom_range(99, 10));
         3: return b2da_pkg::VALUE_W'($urandom_range(999, 100));
         4: return b2da_pkg::VALUE_W'($urandom_range(9999, 1000));
         default: return b2da_pkg::VALUE_W'($urandom_range(65535, 10000));
      endcase
   endfunction

   // driver: a word leaves on start && !busy; start is held through busy
   // and only the decision for the following cycle is written once per edge
   always @(posedge clock) begin
      logic                         next_start;
      logic [b2da_pkg::VALUE_W-1:0] next_word;
      next_start = start;
      next_word  = req_value;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         if (start && !busy) begin
            // beat taken at this edge, predict its characters now
            queue_decimal_digits(req_value);
            void'(words_to_send.pop_front());
            words_accepted++;
            next_start = 1'b0;
         end
         if (!next_start && words_to_send.size() > 0 &&
             $urandom_range(99) >= sender_idle_pct) begin
            next_start = 1'b1;
            next_word  = words_to_send[0];
         end
      end
      start     <= next_start;
      req_value <= next_word;
   end

   // monitor: every strobe must match the oldest waiting character
   always @(posedge clock) begin
      digit_beat_type want;
      if (!reset && rsp_valid) begin
         if (pending_digits.size() == 0) begin
            note_fault($sformatf("unexpected char %0d last %0b", rsp_digit_char, rsp_last));
         end else begin
            want = pending_digits.pop_front();
            digits_checked++;
            if (rsp_digit_char !== want.digit_char)
               note_fault($sformatf("digit_char expected %0d got %0d",
                                    want.digit_char, rsp_digit_char));
            if (rsp_last !== want.last)
               note_fault($sformatf("last expected %0b got %0b (char %0d)",
                                    want.last, rsp_last, want.digit_char));
         end
      end
   end

   // watchdog: any accepted beat on either side resets the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: no progress for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part: place boundaries, zero, all ones, inner zeros
      for (int i = 0; i < NUM_DIRECTED; i++) words_to_send.push_back(DIRECTED[i]);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         sender_idle_pct = PHASE_IDLE[phase];
         for (int n = 0; n < WORDS_PER_PHASE; n++) words_to_send.push_back(pick_word());
         // let the phase drain fully before the idle pattern changes
         while (words_to_send.size() > 0 || pending_digits.size() > 0 || start)
            @(posedge clock);
      end

      // trailing pause catches any stray characters after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_digits.size() > 0)
         note_fault($sformatf("%0d characters never arrived", pending_digits.size()));

      $display("tb: %0d words converted, %0d characters checked, %0d faults",
               words_accepted, digits_checked, fault_count);
      $display("tb: words by digit count 1..5: %0d %0d %0d %0d %0d",
               words_by_length[1], words_by_length[2], words_by_length[3],
               words_by_length[4], words_by_length[5]);
      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
